>>> rtl/iirdf1_pkg.sv
// Shared constants, codes and types of the direct form I IIR filter.
package iirdf1_pkg;

    // Filter order and derived sizes
    localparam int ORDER  = 64;
    localparam int TAPS   = ORDER + 1;
    localparam int TAP_W  = $clog2(ORDER + 1);
    localparam int RING_W = (ORDER > 1) ? $clog2(ORDER) : 1;
    localparam int HIST_AW = $clog2(2 * ORDER);
    localparam int COEF_AW = $clog2(2 * TAPS);

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int COEF_W   = 32;
    localparam int HIST_W   = 32;
    localparam int INDEX_W  = 8;
    localparam int PROD_W   = 64;
    localparam int ACC_W    = 56;

    // Request kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_FILTER = 2'd0,
        FUNC_LOAD_B = 2'd1,
        FUNC_LOAD_A = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    // Control that travels with one read of the coefficient and history memories
    typedef struct packed {
        logic valid;   // a term is issued
        logic a_term;  // denominator term, else numerator term
        logic first;   // b[0] times the current sample
        logic mask;    // history entry not filled yet, reads as zero
        logic clear;   // start of a new sample, clear the accumulator
    } mac_ctl_t;

endpackage

>>> rtl/iirdf1_mac.sv
// Shared multiplier and accumulator that sums all filter terms of one sample.
module iirdf1_mac (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  iirdf1_pkg::mac_ctl_t                 ctl,
    input  logic signed [iirdf1_pkg::COEF_W-1:0]   coef_q,
    input  logic signed [iirdf1_pkg::HIST_W-1:0]   hist_q,
    input  logic signed [iirdf1_pkg::SAMPLE_W-1:0] x0,
    output logic signed [iirdf1_pkg::ACC_W-1:0]    acc,
    output logic                                 busy
);
    import iirdf1_pkg::*;

    logic signed [HIST_W-1:0] opnd;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_vld_reg;
    logic                     prod_a_reg;
    logic signed [ACC_W-1:0]  a_shift;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  acc_reg;

    // Select the history operand, zero for entries not yet filled
    always_comb begin
        if (ctl.first) begin
            opnd = HIST_W'(x0);
        end else if (ctl.mask) begin
            opnd = '0;
        end else if (ctl.a_term) begin
            opnd = hist_q;
        end else begin
            opnd = HIST_W'(signed'(hist_q[SAMPLE_W-1:0]));
        end
    end

    // Scale the denominator product down to the accumulator's Q.24 and negate it
    always_comb begin
        a_shift = ACC_W'(prod_reg >>> 16);
        if (prod_a_reg) begin
            term = -a_shift;
        end else begin
            term = prod_reg[ACC_W-1:0];
        end
    end

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.valid;
        end
        prod_a_reg <= ctl.a_term;
        prod_reg   <= coef_q * opnd;
    end

    // Accumulate stage
    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + term;
        end
    end

    assign acc  = acc_reg;
    assign busy = prod_vld_reg;

endmodule

>>> rtl/iir_direct_form_one_filter.sv
// Direct form I IIR filter top level: request sequencer, memories and output register.
// Requests enter on the s_ stream: a load request (tuser 1 numerator, 2 denominator)
// writes one Q7.24 coefficient and gives no result; a load with an
// index above ORDER, and tuser 3, are dropped. A filter request (tuser 0) holds off
// the next request until its result is placed in the output register: one shared
// 32x32 multiplier steps through the numerator and denominator terms one per cycle,
// reading a coefficient memory and a history memory, then the new input and output
// history words are written back in turn. The result leaves through an output
// register on the m_ stream; the next request is taken while it waits. Both history
// lines read as zero after reset through a fill count, so no clearing pass is needed.
// Coefficients must be loaded before filtering; an unloaded entry gives undefined output.
module iir_direct_form_one_filter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // sample_in[15:0], coef_index[23:16], coef_value[55:24]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // sample_out[15:0]
    output logic [0:0]  m_tuser    // clipped[0]
);
    import iirdf1_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_FIN,
        S_WRY,
        S_EMIT
    } state_t;

    state_t state_reg;

    // Request fields
    func_t                      in_func;
    logic signed [SAMPLE_W-1:0] in_sample;
    logic [INDEX_W-1:0]         in_index;
    logic signed [COEF_W-1:0]   in_coef;
    logic                       in_acc;

    assign in_func   = func_t'(s_tuser);
    assign in_sample = s_tdata[15:0];
    assign in_index  = s_tdata[23:16];
    assign in_coef   = s_tdata[55:24];
    assign in_acc    = s_tvalid && s_tready;

    // Sequencer registers
    logic [TAP_W-1:0]           tap_reg;
    logic                       phase_reg;
    logic [RING_W-1:0]          rd_ptr_reg;
    logic [RING_W-1:0]          wr_ptr_reg;
    logic [TAP_W-1:0]           fill_reg;
    logic signed [SAMPLE_W-1:0] x0_reg;
    logic signed [HIST_W-1:0]   y_reg;
    logic [SAMPLE_W-1:0]        out_data_reg;
    logic                       out_clip_reg;
    logic                       m_tvalid_reg;
    logic [SAMPLE_W-1:0]        m_data_reg;
    logic                       m_clip_reg;
    mac_ctl_t                   s1_ctl_reg;

    // Memories
    logic [COEF_W-1:0] coef_mem [2*TAPS];
    logic [HIST_W-1:0] hist_mem [2*ORDER];
    logic [COEF_W-1:0] coef_q_reg;
    logic [HIST_W-1:0] hist_q_reg;

    logic               coef_we;
    logic [COEF_AW-1:0] coef_waddr;
    logic [COEF_AW-1:0] coef_raddr;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_waddr;
    logic [HIST_W-1:0]  hist_wdata;
    logic [HIST_AW-1:0] hist_raddr;

    // Datapath
    logic signed [ACC_W-1:0]  acc;
    logic                     mac_busy;
    mac_ctl_t                 iss_ctl;
    logic signed [ACC_W-9:0]  hist_full;
    logic signed [HIST_W-1:0] y_next;
    logic signed [ACC_W-1:0]  biased;
    logic signed [ACC_W-25:0] whole;
    logic [SAMPLE_W-1:0]      out_next;
    logic                     clip_next;
    logic [RING_W-1:0]        rd_ptr_dec;
    logic [RING_W-1:0]        wr_ptr_dec;

    assign s_tready = (state_reg == S_IDLE);

    // Coefficient writes come from load requests
    assign coef_we = in_acc && ((in_func == FUNC_LOAD_B) || (in_func == FUNC_LOAD_A))
                     && (in_index <= INDEX_W'(ORDER));
    assign coef_waddr = (in_func == FUNC_LOAD_A) ? COEF_AW'(TAPS) + COEF_AW'(in_index)
                                                 : COEF_AW'(in_index);

    // Issue addresses of the current term
    assign coef_raddr = phase_reg ? COEF_AW'(TAPS) + COEF_AW'(tap_reg) : COEF_AW'(tap_reg);
    assign hist_raddr = phase_reg ? HIST_AW'(ORDER) + HIST_AW'(rd_ptr_reg)
                                  : HIST_AW'(rd_ptr_reg);

    always_comb begin
        iss_ctl        = '0;
        iss_ctl.valid  = (state_reg == S_RUN);
        iss_ctl.a_term = phase_reg;
        iss_ctl.first  = (tap_reg == '0);
        iss_ctl.mask   = (tap_reg > fill_reg);
        iss_ctl.clear  = in_acc && (in_func == FUNC_FILTER);
    end

    // History write-back: input sample first, then the new output word
    assign hist_we    = (state_reg == S_FIN) || (state_reg == S_WRY);
    assign hist_waddr = (state_reg == S_WRY) ? HIST_AW'(ORDER) + HIST_AW'(wr_ptr_reg)
                                             : HIST_AW'(wr_ptr_reg);
    assign hist_wdata = (state_reg == S_WRY) ? y_reg : HIST_W'(x0_reg);

    assign rd_ptr_dec = (rd_ptr_reg == '0) ? RING_W'(ORDER - 1) : rd_ptr_reg - 1'b1;
    assign wr_ptr_dec = (wr_ptr_reg == '0) ? RING_W'(ORDER - 1) : wr_ptr_reg - 1'b1;

    // Round the sum to Q16.16 history and to a truncated, saturated sample
    always_comb begin
        hist_full = (ACC_W-8)'(acc >>> 8);
        if (hist_full > (ACC_W-8)'(32'sh7fffffff)) begin
            y_next = 32'sh7fffffff;
        end else if (hist_full < -(ACC_W-8)'(33'sh080000000)) begin
            y_next = 32'sh80000000;
        end else begin
            y_next = hist_full[HIST_W-1:0];
        end
        biased = acc[ACC_W-1] ? acc + ACC_W'(24'hffffff) : acc;
        whole  = (ACC_W-24)'(biased >>> 24);
        if (whole > (ACC_W-24)'(32767)) begin
            out_next  = 16'h7fff;
            clip_next = 1'b1;
        end else if (whole < -(ACC_W-24)'(32768)) begin
            out_next  = 16'h8000;
            clip_next = 1'b1;
        end else begin
            out_next  = whole[SAMPLE_W-1:0];
            clip_next = 1'b0;
        end
    end

    // Coefficient memory
    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[coef_waddr] <= in_coef;
        end
        coef_q_reg <= coef_mem[coef_raddr];
    end

    // History memory
    always_ff @(posedge aclk) begin
        if (hist_we) begin
            hist_mem[hist_waddr] <= hist_wdata;
        end
        hist_q_reg <= hist_mem[hist_raddr];
    end

    iirdf1_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (s1_ctl_reg),
        .coef_q  (coef_q_reg),
        .hist_q  (hist_q_reg),
        .x0      (x0_reg),
        .acc     (acc),
        .busy    (mac_busy)
    );

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            tap_reg      <= '0;
            phase_reg    <= 1'b0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end else begin
            s1_ctl_reg <= iss_ctl;
            // drop the result once taken, unless the emit step refills it
            if (m_tvalid_reg && m_tready && (state_reg != S_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc && (in_func == FUNC_FILTER)) begin
                        x0_reg     <= in_sample;
                        tap_reg    <= '0;
                        phase_reg  <= 1'b0;
                        rd_ptr_reg <= wr_ptr_dec;
                        state_reg  <= S_RUN;
                    end
                end
                S_RUN: begin
                    // advance through b[0], then b[i] and a[i] for each tap
                    if (tap_reg == '0) begin
                        tap_reg <= tap_reg + 1'b1;
                    end else if (!phase_reg) begin
                        phase_reg <= 1'b1;
                    end else begin
                        phase_reg  <= 1'b0;
                        rd_ptr_reg <= rd_ptr_dec;
                        if (tap_reg == TAP_W'(ORDER)) begin
                            state_reg <= S_DRAIN;
                        end else begin
                            tap_reg <= tap_reg + 1'b1;
                        end
                    end
                end
                S_DRAIN: begin
                    if (!s1_ctl_reg.valid && !mac_busy) begin
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    y_reg        <= y_next;
                    out_data_reg <= out_next;
                    out_clip_reg <= clip_next;
                    state_reg    <= S_WRY;
                end
                S_WRY: begin
                    wr_ptr_reg <= (wr_ptr_reg == RING_W'(ORDER - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
                    if (fill_reg != TAP_W'(ORDER)) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    // hold until the output register is free
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_data_reg   <= out_data_reg;
                        m_clip_reg   <= out_clip_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_clip_reg;

    // The tap counter never runs past the last tap while terms are issued
    a_tap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RUN) |-> (tap_reg <= TAP_W'(ORDER)))
        else $error("tap counter past last tap");

    // History write-back never overlaps term reads in flight
    a_no_wb_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        hist_we |-> (!s1_ctl_reg.valid && !mac_busy))
        else $error("history write while terms in flight");

    // A new result appears only from the emit step
    a_emit_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg && !m_tready)) |-> $past(state_reg == S_EMIT))
        else $error("result without finished sample");

    // The fill count stays within the history depth
    a_fill_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= TAP_W'(ORDER))
        else $error("fill count beyond history depth");

endmodule

>>> tb/sv/iir_direct_form_one_filter_tb.sv
// Self-checking stream testbench of the direct form I IIR filter with its own fixed-point predictor.
`timescale 1ns / 1ps

module iir_direct_form_one_filter_tb;
    import iirdf1_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 4 * (2 * ORDER + 8);
    localparam int PHASE_ITEMS  = 100;
    localparam int LONG_HOLD    = 2500;
    localparam int HOLD_AT      = 120;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX  = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN  = 16'sh8000;
    localparam logic signed [COEF_W-1:0]   ONE_Q24  = 32'sh0100_0000;
    localparam logic signed [COEF_W-1:0]   HALF_Q24 = 32'sh0080_0000;
    localparam logic signed [COEF_W-1:0]   COEF_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COEF_W-1:0]   COEF_MIN = 32'sh8000_0000;

    // Coefficient sets loaded between phases
    typedef enum int {
        SET_ZERO,
        SET_SMALL,
        SET_FULL,
        SET_EXTREME,
        SET_SPARSE
    } coef_set_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       clipped;
    } filt_result_t;

    typedef struct packed {
        func_t                      func;
        logic signed [SAMPLE_W-1:0] smp;
        logic [INDEX_W-1:0]         idx;
        logic signed [COEF_W-1:0]   val;
        logic                       typed;
        logic signed [SAMPLE_W-1:0] exp_out;
        logic                       exp_clip;
    } stim_row_t;

    localparam int N_DIRECTED = 25;

    // Directed requests; typed rows carry a result read straight off the filter equation
    localparam stim_row_t DIRECTED [N_DIRECTED] = '{
        '{FUNC_LOAD_B, 16'sd0,    8'd0,          ONE_Q24,  1'b0, 16'sd0,    1'b0},
        '{FUNC_FILTER, SMP_MAX,   8'd0,          32'sd0,   1'b1, SMP_MAX,   1'b0},
        '{FUNC_FILTER, SMP_MIN,   8'd0,          32'sd0,   1'b1, SMP_MIN,   1'b0},
        '{FUNC_FILTER, 16'sd0,    8'd0,          32'sd0,   1'b1, 16'sd0,    1'b0},
        '{FUNC_LOAD_B, 16'sd0,    8'd0,          COEF_MAX, 1'b0, 16'sd0,    1'b0},
        '{FUNC_FILTER, SMP_MAX,   8'd0,          32'sd0,   1'b1, SMP_MAX,   1'b1},
        '{FUNC_FILTER, SMP_MIN,   8'd0,          32'sd0,   1'b1, SMP_MIN,   1'b1},
        '{FUNC_FILTER, 16'sd1,    8'd0,          32'sd0,   1'b1, 16'sd127,  1'b0},
        '{FUNC_FILTER, -16'sd1,   8'd0,          32'sd0,   1'b1, -16'sd127, 1'b0},
        '{FUNC_LOAD_B, 16'sd0,    8'd0,          COEF_MIN, 1'b0, 16'sd0,    1'b0},
        '{FUNC_FILTER, 16'sd1,    8'd0,          32'sd0,   1'b1, -16'sd128, 1'b0},
        '{FUNC_FILTER, SMP_MIN,   8'd0,          32'sd0,   1'b1, SMP_MAX,   1'b1},
        '{FUNC_FILTER, SMP_MAX,   8'd0,          32'sd0,   1'b1, SMP_MIN,   1'b1},
        '{FUNC_LOAD_B, 16'sh5A5A, 8'hFF,         ONE_Q24,  1'b0, 16'sd0,    1'b0},
        '{FUNC_LOAD_A, 16'sd0,    8'(ORDER + 1), COEF_MAX, 1'b0, 16'sd0,    1'b0},
        '{FUNC_NONE,   -16'sd1,   8'hFF,         -32'sd1,  1'b0, 16'sd0,    1'b0},
        '{FUNC_FILTER, 16'sd1,    8'd0,          32'sd0,   1'b1, -16'sd128, 1'b0},
        '{FUNC_LOAD_B, 16'sd0,    8'(ORDER),     COEF_MAX, 1'b0, 16'sd0,    1'b0},
        '{FUNC_LOAD_A, 16'sd0,    8'(ORDER),     COEF_MIN, 1'b0, 16'sd0,    1'b0},
        '{FUNC_LOAD_A, 16'sd0,    8'd1,          HALF_Q24, 1'b0, 16'sd0,    1'b0},
        '{FUNC_LOAD_A, 16'sd0,    8'd0,          COEF_MAX, 1'b0, 16'sd0,    1'b0},
        '{FUNC_FILTER, 16'sd12345, 8'd0,         32'sd0,   1'b0, 16'sd0,    1'b0},
        '{FUNC_FILTER, -16'sd20000, 8'd0,        32'sd0,   1'b0, 16'sd0,    1'b0},
        '{FUNC_FILTER, SMP_MAX,   8'd0,          32'sd0,   1'b0, 16'sd0,    1'b0},
        '{FUNC_FILTER, 16'sd0,    8'd0,          32'sd0,   1'b0, 16'sd0,    1'b0}
    };

    localparam coef_set_t PHASE_SETS [4] = '{SET_SMALL, SET_EXTREME, SET_FULL, SET_SPARSE};

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;   // sample_in[15:0], coef_index[23:16], coef_value[55:24]
    logic [1:0]  s_tuser;   // func[1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // sample_out[15:0]
    logic [0:0]  m_tuser;   // clipped[0]

    // Predictor state: both history lines and both coefficient tables
    logic signed [SAMPLE_W-1:0] x_line   [0:ORDER];
    logic signed [HIST_W-1:0]   y_line   [0:ORDER];
    logic signed [COEF_W-1:0]   num_coef [0:ORDER];
    logic signed [COEF_W-1:0]   den_coef [0:ORDER];

    filt_result_t expected_results [$];
    int           error_count;
    int           results_seen;
    int           cycle_count;
    bit           tx_burst;

    iir_direct_form_one_filter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at cycle %0d: %s", cycle_count, msg);
        error_count++;
    endtask

    // Apply one request to the predictor; a filter request yields its expected result
    function automatic void filter_request(input func_t f, input logic signed [SAMPLE_W-1:0] smp,
                                           input logic [INDEX_W-1:0] idx,
                                           input logic signed [COEF_W-1:0] val,
                                           output bit gives, output filt_result_t res);
        longint acc;
        longint term;
        longint hist;
        longint whole;
        gives = 1'b0;
        res   = '0;
        if (f == FUNC_LOAD_B || f == FUNC_LOAD_A) begin
            if (idx <= ORDER) begin
                if (f == FUNC_LOAD_B) num_coef[idx[TAP_W-1:0]] = val;
                else den_coef[idx[TAP_W-1:0]] = val;
            end
        end else if (f == FUNC_FILTER) begin
            x_line[0] = smp;
            acc = longint'(num_coef[0]) * longint'(smp);
            for (int i = 1; i <= ORDER; i++) begin
                acc  += longint'(num_coef[i]) * longint'(x_line[i]);
                term  = longint'(den_coef[i]) * longint'(y_line[i]);
                acc  -= term >>> 16;
            end
            // New output history word, Q16.16, saturated
            hist = acc >>> 8;
            if (hist > longint'(32'sh7FFF_FFFF)) hist = longint'(32'sh7FFF_FFFF);
            if (hist < longint'(32'sh8000_0000)) hist = longint'(32'sh8000_0000);
            y_line[0] = hist[31:0];
            for (int i = ORDER; i > 0; i--) begin
                x_line[i] = x_line[i - 1];
                y_line[i] = y_line[i - 1];
            end
            // Truncate toward zero, then saturate to 16 bits
            whole = (acc >= 0) ? (acc >>> 24) : -((-acc) >>> 24);
            res.clipped = 1'b0;
            if (whole > 32767) begin
                whole = 32767;
                res.clipped = 1'b1;
            end else if (whole < -32768) begin
                whole = -32768;
                res.clipped = 1'b1;
            end
            res.sample_out = whole[15:0];
            gives = 1'b1;
        end
    endfunction

    function automatic logic signed [COEF_W-1:0] draw_coef(input coef_set_t kind, input int tap,
                                                          input bit den);
        int span;
        logic signed [COEF_W-1:0] v;
        v = '0;
        case (kind)
            SET_SMALL: begin
                span = den ? (1 << 17) : (1 << 21);
                v = int'($urandom_range(0, 2 * span)) - span;
            end
            SET_FULL: v = $urandom();
            SET_EXTREME: begin
                case ($urandom_range(0, 2))
                    0: v = COEF_MAX;
                    1: v = COEF_MIN;
                    default: v = '0;
                endcase
            end
            SET_SPARSE: begin
                span = 1 << 23;
                if (tap <= 2) v = int'($urandom_range(0, 2 * span)) - span;
            end
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] draw_sample();
        logic signed [SAMPLE_W-1:0] s;
        case ($urandom_range(0, 9))
            0: s = SMP_MAX;
            1: s = SMP_MIN;
            default: s = SAMPLE_W'($urandom());
        endcase
        return s;
    endfunction

    // Offer one request after a random gap, none in burst mode, and record what it should produce
    task automatic send_request(input func_t f, input logic signed [SAMPLE_W-1:0] smp,
                                input logic [INDEX_W-1:0] idx,
                                input logic signed [COEF_W-1:0] val,
                                input bit typed, input filt_result_t typed_res);
        int gap;
        bit gives;
        filt_result_t res;
        gap = tx_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {val, idx, smp};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        filter_request(f, smp, idx, val, gives, res);
        if (gives) expected_results.push_back(typed ? typed_res : res);
    endtask

    // Load both full tables with one coefficient set
    task automatic load_coef_set(input coef_set_t kind);
        for (int t = 0; t <= ORDER; t++) begin
            send_request(FUNC_LOAD_B, draw_sample(), 8'(t), draw_coef(kind, t, 1'b0), 1'b0, '0);
            send_request(FUNC_LOAD_A, draw_sample(), 8'(t), draw_coef(kind, t, 1'b1), 1'b0, '0);
        end
    endtask

    // Hold the sender until every expected result has come out
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // Run timeout
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: check each accepted result, stall at random, hold off once for a long stretch
    initial begin
        int stall_left;
        bit rx_burst;
        bit long_done;
        filt_result_t want;
        stall_left   = 0;
        rx_burst     = 1'b0;
        long_done    = 1'b0;
        results_seen = 0;
        m_tready     = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d clip %0d",
                                              $signed(m_tdata), m_tuser[0]));
                end else begin
                    want = expected_results.pop_front();
                    if (m_tdata !== want.sample_out)
                        report_mismatch($sformatf("sample_out %0d, want %0d",
                                                  $signed(m_tdata), want.sample_out));
                    if (m_tuser[0] !== want.clipped)
                        report_mismatch($sformatf("clipped %0d, want %0d",
                                                  m_tuser[0], want.clipped));
                end
                results_seen++;
                if (results_seen % 32 == 0) rx_burst = ($urandom_range(0, 3) == 0);
                if (!long_done && results_seen == HOLD_AT) begin
                    stall_left = LONG_HOLD;
                    long_done  = 1'b1;
                end else begin
                    stall_left = rx_burst ? 0 : $urandom_range(0, 10);
                end
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    // Request side: reset, table setup, directed rows, then random phases
    initial begin
        int counted;
        int pick;
        int tap;
        func_t f;
        logic signed [COEF_W-1:0] v;
        filt_result_t typed_res;
        coef_set_t kind;

        error_count = 0;
        tx_burst    = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = FUNC_FILTER;
        aresetn     = 1'b0;
        for (int i = 0; i <= ORDER; i++) begin
            x_line[i]   = '0;
            y_line[i]   = '0;
            num_coef[i] = '0;
            den_coef[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Every table entry is written before the first sample
        load_coef_set(SET_ZERO);

        for (int k = 0; k < N_DIRECTED; k++) begin
            typed_res.sample_out = DIRECTED[k].exp_out;
            typed_res.clipped    = DIRECTED[k].exp_clip;
            send_request(DIRECTED[k].func, DIRECTED[k].smp, DIRECTED[k].idx, DIRECTED[k].val,
                         DIRECTED[k].typed, typed_res);
        end

        for (int p = 0; p < 4; p++) begin
            kind = PHASE_SETS[p];
            drain_results();
            tx_burst = ($urandom_range(0, 3) == 0);
            load_coef_set(kind);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 78) begin
                    send_request(FUNC_FILTER, draw_sample(), INDEX_W'($urandom()), $urandom(),
                                 1'b0, '0);
                    counted++;
                end else if (pick < 88) begin
                    f   = ($urandom_range(0, 1) == 1) ? FUNC_LOAD_A : FUNC_LOAD_B;
                    tap = $urandom_range(0, ORDER);
                    v   = ($urandom_range(0, 3) == 0) ? $urandom()
                                                      : draw_coef(kind, tap, f == FUNC_LOAD_A);
                    send_request(f, draw_sample(), 8'(tap), v, 1'b0, '0);
                    counted++;
                end else if (pick < 94) begin
                    f = ($urandom_range(0, 1) == 1) ? FUNC_LOAD_A : FUNC_LOAD_B;
                    send_request(f, draw_sample(), 8'($urandom_range(ORDER + 1, 255)),
                                 $urandom(), 1'b0, '0);
                end else begin
                    send_request(FUNC_NONE, draw_sample(), INDEX_W'($urandom()), $urandom(),
                                 1'b0, '0);
                end
            end
        end

        // Drain, then let the block finish any trailing work
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
